[hw/rtl/rgb_to_yuv420_bt601_top_assert.svh]
// Assertion macros shared by the RGB to YUV 4:2:0 converter RTL.
`ifndef RGB_TO_YUV420_BT601_TOP_ASSERT_SVH
`define RGB_TO_YUV420_BT601_TOP_ASSERT_SVH

// Checked outside reset only.
`define R2Y_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define R2Y_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rgb2yuv_pkg.sv]
// Types, sizes and coefficients of the RGB to YUV 4:2:0 converter.
package rgb2yuv_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PAIR_SLOTS = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(PAIR_SLOTS);
  localparam int PAIRS_W    = COL_W + 1;
  localparam int CFG_W      = 12;
  localparam int FW_RESET   = 640;

  // BT.601 studio-swing coefficients (magnitudes, signs applied at use)
  localparam int Y_COEF_R   = 66;
  localparam int Y_COEF_G   = 129;
  localparam int Y_COEF_B   = 25;
  localparam int ROUND      = 128;
  localparam int Y_OFFSET   = 16;
  localparam int U_COEF_R   = 38;
  localparam int U_COEF_G   = 74;
  localparam int UV_COEF_HI = 112;
  localparam int V_COEF_G   = 94;
  localparam int V_COEF_B   = 18;
  localparam int UV_OFFSET  = 128;
  localparam int BYTE_MAX   = 255;

  localparam int LUMA_W   = 17;
  localparam int CHROMA_W = 18;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_pix_t;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } rgb_sum_t;

  localparam int SUM_W = $bits(rgb_sum_t);

  typedef struct packed {
    logic ld2;
    logic ld3;
  } pipe_ctl_t;

  function automatic logic [7:0] clamp_byte(input logic signed [CHROMA_W-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > CHROMA_W'(BYTE_MAX)) begin
      res = 8'hff;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/rgb2yuv_ram.sv]
// Generic single-port RAM with registered read data.
module rgb2yuv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/rgb2yuv_lane.sv]
// Luma lane: BT.601 Y of one pixel, registered.
module rgb2yuv_lane (
  input  logic                  clk,
  input  logic                  ld,
  input  rgb2yuv_pkg::rgb_pix_t pix,
  output logic [7:0]            luma_r
);

  localparam int LW = rgb2yuv_pkg::LUMA_W;

  logic [LW-1:0] y_sum;
  logic [8:0]    y_off;
  logic [7:0]    luma_nxt;

  always_comb begin
    y_sum = LW'(rgb2yuv_pkg::Y_COEF_R) * LW'(pix.r)
          + LW'(rgb2yuv_pkg::Y_COEF_G) * LW'(pix.g)
          + LW'(rgb2yuv_pkg::Y_COEF_B) * LW'(pix.b)
          + LW'(rgb2yuv_pkg::ROUND);
    y_off = y_sum[LW-1:8] + 9'(rgb2yuv_pkg::Y_OFFSET);
    if (y_off > 9'(rgb2yuv_pkg::BYTE_MAX)) begin
      luma_nxt = 8'hff;
    end else begin
      luma_nxt = y_off[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      luma_r <= luma_nxt;
    end
  end

endmodule

[hw/rtl/rgb2yuv_chroma.sv]
// Chroma merge: averages a 2x2 block and forms U and V over two stages.
module rgb2yuv_chroma (
  input  logic                   clk,
  input  rgb2yuv_pkg::pipe_ctl_t ctl,
  input  logic                   odd_row,
  input  rgb2yuv_pkg::rgb_sum_t  pair_sum,
  input  rgb2yuv_pkg::rgb_sum_t  stored_sum,
  output logic                   chroma_valid_r,
  output logic [7:0]             chroma_blue_r,
  output logic [7:0]             chroma_red_r
);

  localparam int CW = rgb2yuv_pkg::CHROMA_W;
  localparam logic signed [CW-1:0] C_UR  = CW'(rgb2yuv_pkg::U_COEF_R);
  localparam logic signed [CW-1:0] C_UG  = CW'(rgb2yuv_pkg::U_COEF_G);
  localparam logic signed [CW-1:0] C_HI  = CW'(rgb2yuv_pkg::UV_COEF_HI);
  localparam logic signed [CW-1:0] C_VG  = CW'(rgb2yuv_pkg::V_COEF_G);
  localparam logic signed [CW-1:0] C_VB  = CW'(rgb2yuv_pkg::V_COEF_B);
  localparam logic signed [CW-1:0] C_RND = CW'(rgb2yuv_pkg::ROUND);
  localparam logic signed [CW-1:0] C_OFS = CW'(rgb2yuv_pkg::UV_OFFSET);

  logic [9:0] tot_r, tot_g, tot_b;
  logic [7:0] avg_r_r, avg_g_r, avg_b_r;
  logic       cv2_r;

  logic signed [CW-1:0] sr, sg, sb;
  logic signed [CW-1:0] u_sum, v_sum, u_off, v_off;

  // block average: floor of the four-pixel sum over four
  always_comb begin
    tot_r = 10'(stored_sum.r) + 10'(pair_sum.r);
    tot_g = 10'(stored_sum.g) + 10'(pair_sum.g);
    tot_b = 10'(stored_sum.b) + 10'(pair_sum.b);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      avg_r_r <= tot_r[9:2];
      avg_g_r <= tot_g[9:2];
      avg_b_r <= tot_b[9:2];
      cv2_r   <= odd_row;
    end
  end

  always_comb begin
    sr    = $signed(CW'(avg_r_r));
    sg    = $signed(CW'(avg_g_r));
    sb    = $signed(CW'(avg_b_r));
    u_sum = C_RND - C_UR * sr - C_UG * sg + C_HI * sb;
    v_sum = C_RND + C_HI * sr - C_VG * sg - C_VB * sb;
    u_off = (u_sum >>> 8) + C_OFS;
    v_off = (v_sum >>> 8) + C_OFS;
  end

  // zero chroma on even rows
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      chroma_valid_r <= cv2_r;
      chroma_blue_r  <= cv2_r ? rgb2yuv_pkg::clamp_byte(u_off) : 8'd0;
      chroma_red_r   <= cv2_r ? rgb2yuv_pkg::clamp_byte(v_off) : 8'd0;
    end
  end

endmodule

[hw/rtl/rgb_to_yuv420_bt601_top.sv]
// Top level of the streaming BT.601 RGB to YUV 4:2:0 converter.
//
//   channel | direction | handshake            | beat carries
//   in_     | input     | in_valid / in_ready   | start flag, two RGB pixels
//   out_    | output    | out_valid / out_ready | two Y, chroma flag, U, V
//   cfg_    | input     | cfg_valid / cfg_ready | frame width (always ready)
//
// One pixel pair per clock while out_ready holds; a beat passes stages 1, 2 and 3 in turn.
// The line store is one single-port RAM, written on even rows and read on odd rows.
// Each of the three stages holds while the next is full and stalled; an empty
// stage still takes a beat, so input keeps flowing while the output waits.
// Synchronous active-low reset empties the pipe, zeroes column and row parity,
// and sets the frame width to 640; the line store is not cleared.
`include "rgb_to_yuv420_bt601_top_assert.svh"

module rgb_to_yuv420_bt601_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_of_region,
  input  logic [7:0]                        in_red_left,
  input  logic [7:0]                        in_green_left,
  input  logic [7:0]                        in_blue_left,
  input  logic [7:0]                        in_red_right,
  input  logic [7:0]                        in_green_right,
  input  logic [7:0]                        in_blue_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_luma_left,
  output logic [7:0]                        out_luma_right,
  output logic                              out_chroma_valid,
  output logic [7:0]                        out_chroma_blue,
  output logic [7:0]                        out_chroma_red,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_frame_width
);

  localparam int COL_W   = rgb2yuv_pkg::COL_W;
  localparam int PAIRS_W = rgb2yuv_pkg::PAIRS_W;
  localparam int CFG_W   = rgb2yuv_pkg::CFG_W;

  logic [CFG_W-1:0]   frame_width_r;
  logic [CFG_W-2:0]   fw_half;
  logic [PAIRS_W-1:0] pairs;

  logic [COL_W-1:0] col_r, col_nxt, col_eff;
  logic             odd_r, odd_nxt, odd_eff;
  logic             row_last;
  logic             in_acc;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  rgb2yuv_pkg::pipe_ctl_t ctl;

  rgb2yuv_pkg::rgb_pix_t pix_l, pix_r, pix_l1_r, pix_r1_r;
  rgb2yuv_pkg::rgb_sum_t pair_sum, sum1_r, stored_sum;
  logic                  odd1_r;

  logic       ram_we, ram_re;
  logic [7:0] luma_l2, luma_r2;
  logic [7:0] luma_l3_r, luma_r3_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= CFG_W'(rgb2yuv_pkg::FW_RESET);
    end else if (cfg_valid && cfg_ready) begin
      frame_width_r <= cfg_frame_width;
    end
  end

  // pairs per row: half the width, at least one, at most the line store size
  always_comb begin
    fw_half = frame_width_r[CFG_W-1:1];
    if (fw_half == '0) begin
      pairs = PAIRS_W'(1);
    end else if (int'(fw_half) > rgb2yuv_pkg::PAIR_SLOTS) begin
      pairs = PAIRS_W'(rgb2yuv_pkg::PAIR_SLOTS);
    end else begin
      pairs = PAIRS_W'(fw_half);
    end
  end

  // pipeline flow
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_acc   = in_valid && in_ready;
  assign ctl.ld2  = v1_r && rdy2;
  assign ctl.ld3  = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // column and row parity
  always_comb begin
    col_eff  = in_start_of_region ? '0 : col_r;
    odd_eff  = in_start_of_region ? 1'b0 : odd_r;
    row_last = (PAIRS_W'(col_eff) + PAIRS_W'(1)) >= pairs;
    col_nxt  = row_last ? '0 : col_eff + COL_W'(1);
    odd_nxt  = row_last ? !odd_eff : odd_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
    end
  end

  // stage 0: pair sums, line store access
  always_comb begin
    pix_l      = '{r: in_red_left,  g: in_green_left,  b: in_blue_left};
    pix_r      = '{r: in_red_right, g: in_green_right, b: in_blue_right};
    pair_sum.r = 9'(in_red_left)   + 9'(in_red_right);
    pair_sum.g = 9'(in_green_left) + 9'(in_green_right);
    pair_sum.b = 9'(in_blue_left)  + 9'(in_blue_right);
  end

  assign ram_we = in_acc && !odd_eff;
  assign ram_re = in_acc && odd_eff;

  rgb2yuv_ram #(
    .WIDTH (rgb2yuv_pkg::SUM_W),
    .DEPTH (rgb2yuv_pkg::PAIR_SLOTS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (col_eff),
    .wdata (pair_sum),
    .rdata (stored_sum)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_l1_r <= pix_l;
      pix_r1_r <= pix_r;
      sum1_r   <= pair_sum;
      odd1_r   <= odd_eff;
    end
  end

  // stage 2: luma lanes and block average
  rgb2yuv_lane u_lane_left (
    .clk    (clk),
    .ld     (ctl.ld2),
    .pix    (pix_l1_r),
    .luma_r (luma_l2)
  );

  rgb2yuv_lane u_lane_right (
    .clk    (clk),
    .ld     (ctl.ld2),
    .pix    (pix_r1_r),
    .luma_r (luma_r2)
  );

  rgb2yuv_chroma u_chroma (
    .clk            (clk),
    .ctl            (ctl),
    .odd_row        (odd1_r),
    .pair_sum       (sum1_r),
    .stored_sum     (stored_sum),
    .chroma_valid_r (out_chroma_valid),
    .chroma_blue_r  (out_chroma_blue),
    .chroma_red_r   (out_chroma_red)
  );

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      luma_l3_r <= luma_l2;
      luma_r3_r <= luma_r2;
    end
  end

  assign out_valid      = v3_r;
  assign out_luma_left  = luma_l3_r;
  assign out_luma_right = luma_r3_r;

  `R2Y_ASSERT(a_ram_one_access, !(ram_we && ram_re), "line store written and read at once")
  `R2Y_ASSERT(a_row_wrap, in_acc && row_last |=> col_r == '0, "column did not wrap at row end")
  `R2Y_ASSERT(a_chroma_zero,
    out_valid && !out_chroma_valid |-> out_chroma_blue == 8'd0 && out_chroma_red == 8'd0,
    "chroma not zero on an even-row beat")
  `R2Y_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !v1_r && !v2_r && !v3_r,
    "pipeline not empty after reset")

endmodule

[test/rgb_to_yuv420_bt601_top_tb.sv]
// Self-checking testbench of the BT.601 RGB to YUV 4:2:0 converter.
`timescale 1ns / 100ps

module rgb_to_yuv420_bt601_top_tb;
  import rgb2yuv_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;

  localparam rgb_pix_t PIX_BLACK   = 24'h000000;
  localparam rgb_pix_t PIX_WHITE   = 24'hffffff;
  localparam rgb_pix_t PIX_RED     = 24'hff0000;
  localparam rgb_pix_t PIX_GREEN   = 24'h00ff00;
  localparam rgb_pix_t PIX_BLUE    = 24'h0000ff;
  localparam rgb_pix_t PIX_YELLOW  = 24'hffff00;
  localparam rgb_pix_t PIX_CYAN    = 24'h00ffff;
  localparam rgb_pix_t PIX_MAGENTA = 24'hff00ff;

  typedef struct packed {
    logic     sor;
    rgb_pix_t left;
    rgb_pix_t right;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] y_left;
    logic [7:0] y_right;
    logic       has_chroma;
    logic [7:0] cb;
    logic [7:0] cr;
  } yuv_out_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_start_of_region = 1'b0;
  logic [7:0]       in_red_left = '0;
  logic [7:0]       in_green_left = '0;
  logic [7:0]       in_blue_left = '0;
  logic [7:0]       in_red_right = '0;
  logic [7:0]       in_green_right = '0;
  logic [7:0]       in_blue_right = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_luma_left;
  logic [7:0]       out_luma_right;
  logic             out_chroma_valid;
  logic [7:0]       out_chroma_blue;
  logic [7:0]       out_chroma_red;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_frame_width = '0;

  pixel_pair_t pair_backlog[$];
  yuv_out_t    yuv_expected[$];
  pixel_pair_t beat_on_bus;

  int idle_pct     = 20;
  int errors       = 0;
  int yuv_seen     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  // shadow of the converter state
  logic [CFG_W-1:0] width_reg = CFG_W'(FW_RESET);
  rgb_sum_t         even_sums [PAIR_SLOTS];
  int unsigned      pair_col = 0;
  bit               odd_row = 1'b0;

  rgb_to_yuv420_bt601_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_of_region(in_start_of_region),
    .in_red_left       (in_red_left),
    .in_green_left     (in_green_left),
    .in_blue_left      (in_blue_left),
    .in_red_right      (in_red_right),
    .in_green_right    (in_green_right),
    .in_blue_right     (in_blue_right),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_luma_left     (out_luma_left),
    .out_luma_right    (out_luma_right),
    .out_chroma_valid  (out_chroma_valid),
    .out_chroma_blue   (out_chroma_blue),
    .out_chroma_red    (out_chroma_red),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frame_width   (cfg_frame_width)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] sat_u8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic int unsigned pairs_in_row(input logic [CFG_W-1:0] w);
    int unsigned even_w;
    even_w = {w[CFG_W-1:1], 1'b0};
    if (even_w > MAX_WIDTH) even_w = MAX_WIDTH;
    if (even_w < 2) even_w = 2;
    return even_w / 2;
  endfunction

  function automatic logic [7:0] luma_of_pixel(input rgb_pix_t p);
    int acc;
    acc = 66 * int'(p.r) + 129 * int'(p.g) + 25 * int'(p.b) + 128;
    return sat_u8((acc >>> 8) + 16);
  endfunction

  // Advance the shadow state by one pair and return the converted beat.
  function automatic yuv_out_t convert_pair(input pixel_pair_t beat);
    yuv_out_t    res;
    rgb_sum_t    here;
    rgb_sum_t    above;
    int unsigned slot;
    int unsigned pairs;
    int          avg_r;
    int          avg_g;
    int          avg_b;
    pairs = pairs_in_row(width_reg);
    if (beat.sor) begin
      pair_col = 0;
      odd_row = 1'b0;
    end
    slot = (pair_col < PAIR_SLOTS) ? pair_col : 0;
    here.r = {1'b0, beat.left.r} + {1'b0, beat.right.r};
    here.g = {1'b0, beat.left.g} + {1'b0, beat.right.g};
    here.b = {1'b0, beat.left.b} + {1'b0, beat.right.b};
    res.y_left = luma_of_pixel(beat.left);
    res.y_right = luma_of_pixel(beat.right);
    if (!odd_row) begin
      even_sums[slot] = here;
      res.has_chroma = 1'b0;
      res.cb = 8'd0;
      res.cr = 8'd0;
    end else begin
      above = even_sums[slot];
      avg_r = (int'(above.r) + int'(here.r)) >>> 2;
      avg_g = (int'(above.g) + int'(here.g)) >>> 2;
      avg_b = (int'(above.b) + int'(here.b)) >>> 2;
      res.has_chroma = 1'b1;
      res.cb = sat_u8(((-38 * avg_r - 74 * avg_g + 112 * avg_b + 128) >>> 8) + 128);
      res.cr = sat_u8(((112 * avg_r - 94 * avg_g - 18 * avg_b + 128) >>> 8) + 128);
    end
    if (pair_col + 1 >= pairs) begin
      pair_col = 0;
      odd_row = !odd_row;
    end else begin
      pair_col++;
    end
    return res;
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Pixel pair driver: hold each beat until it is taken, gap at random.
  always @(posedge clk) begin : pair_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        yuv_expected.push_back(convert_pair(beat_on_bus));
      end
      if (!in_valid || in_ready) begin
        if (pair_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          beat_on_bus = pair_backlog.pop_front();
          in_valid <= 1'b1;
          in_start_of_region <= beat_on_bus.sor;
          in_red_left <= beat_on_bus.left.r;
          in_green_left <= beat_on_bus.left.g;
          in_blue_left <= beat_on_bus.left.b;
          in_red_right <= beat_on_bus.right.r;
          in_green_right <= beat_on_bus.right.g;
          in_blue_right <= beat_on_bus.right.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // YUV monitor and receiver stalls.
  always @(posedge clk) begin : yuv_monitor
    yuv_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (yuv_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: expected none, actual Y %0d/%0d", $time,
                   out_luma_left, out_luma_right);
        end else begin
          want = yuv_expected.pop_front();
          check_field("luma_left", want.y_left, out_luma_left);
          check_field("luma_right", want.y_right, out_luma_right);
          check_field("chroma_valid", {7'd0, want.has_chroma}, {7'd0, out_chroma_valid});
          check_field("chroma_blue", want.cb, out_chroma_blue);
          check_field("chroma_red", want.cr, out_chroma_red);
        end
        yuv_seen++;
      end
      // hold off once for a long stretch so the pipe fills and backs up
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && yuv_seen >= 300) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rgb_to_yuv420_bt601_top_tb: errors");
      $finish;
    end
  end

  task automatic queue_pair(input bit sor, input rgb_pix_t l, input rgb_pix_t r);
    pixel_pair_t p;
    p.sor = sor;
    p.left = l;
    p.right = r;
    pair_backlog.push_back(p);
  endtask

  function automatic rgb_pix_t any_pixel();
    rgb_pix_t p;
    p = rgb_pix_t'($urandom);
    // push toward the channel extremes now and then
    if ($urandom_range(9) == 0) begin
      p.r = $urandom_range(1) ? 8'hff : 8'h00;
      p.g = $urandom_range(1) ? 8'hff : 8'h00;
      p.b = $urandom_range(1) ? 8'hff : 8'h00;
    end
    return p;
  endfunction

  task automatic queue_random(input int n, input bit first_sor, input bit noisy);
    bit sor;
    for (int i = 0; i < n; i++) begin
      sor = (i == 0) ? first_sor : (noisy && $urandom_range(39) == 0);
      queue_pair(sor, any_pixel(), any_pixel());
    end
  endtask

  task automatic wait_idle();
    while (pair_backlog.size() != 0 || in_valid || yuv_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_width(input logic [CFG_W-1:0] w);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_frame_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  initial begin : stimulus
    rgb_pix_t         hues [6];
    logic [CFG_W-1:0] w;
    int               pairs;
    int               n;
    int               random_items;
    int               phase;
    hues = '{PIX_BLACK, PIX_WHITE, PIX_RED, PIX_BLUE, PIX_YELLOW, PIX_CYAN};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width: color extremes, then finish the even row and start the odd one
    queue_pair(1'b1, PIX_BLACK, PIX_WHITE);
    queue_pair(1'b0, PIX_RED, PIX_GREEN);
    queue_pair(1'b0, PIX_BLUE, PIX_YELLOW);
    queue_pair(1'b0, PIX_CYAN, PIX_MAGENTA);
    queue_pair(1'b0, PIX_WHITE, PIX_WHITE);
    queue_random(pairs_in_row(CFG_W'(FW_RESET)) - 5 + 12, 1'b0, 1'b0);
    wait_idle();

    // one pair per row: a beat carries chroma when it falls on an odd row
    set_frame_width(CFG_W'(2));
    foreach (hues[i]) begin
      queue_pair(1'b1, hues[i], hues[i]);
      // restart the region where an odd row would come
      if (i == 3) queue_pair(1'b1, hues[i], hues[(i + 1) % 6]);
      queue_pair(1'b0, hues[i], hues[(i + 1) % 6]);
    end
    wait_idle();

    // shrink the width in the middle of an even row
    set_frame_width(CFG_W'(8));
    queue_random(3, 1'b1, 1'b0);
    wait_idle();
    set_frame_width(CFG_W'(4));
    queue_random(5, 1'b0, 1'b0);
    wait_idle();

    // saturating width, then the largest legal one
    set_frame_width(12'hfff);
    queue_random(40, 1'b1, 1'b0);
    wait_idle();
    set_frame_width(CFG_W'(MAX_WIDTH));
    queue_random(40, 1'b1, 1'b0);
    wait_idle();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: w = CFG_W'(0);
        1: w = CFG_W'(1);
        2: w = CFG_W'(3);
        4: w = CFG_W'(64);
        default: begin
          w = CFG_W'(($urandom_range(5) == 0) ? $urandom_range(33, 64)
                                              : $urandom_range(2, 32));
        end
      endcase
      idle_pct = (phase == 4) ? 0 : 20;
      set_frame_width(w);
      pairs = pairs_in_row(w);
      n = pairs * 2 * $urandom_range(1, 2) + $urandom_range(0, pairs);
      queue_random(n / 2, 1'b1, 1'b1);
      // every third phase, pause the sender until the pipe is empty
      if (phase % 3 == 1) wait_idle();
      queue_random(n - n / 2, 1'b0, 1'b1);
      wait_idle();
      random_items += n;
      phase++;
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("rgb_to_yuv420_bt601_top_tb: clean");
    end else begin
      $display("rgb_to_yuv420_bt601_top_tb: errors");
    end
    $finish;
  end

endmodule
